### rtl/hpct_pkg.sv
// ----------------------------------------------------------------------------
// hpct_pkg
// Shared types and constants for the half-duplex PHY collision tracker.
// ----------------------------------------------------------------------------
package hpct_pkg;

	// Fixed field widths of the channel payloads
	localparam int unsigned ID_FIELD_W = 16;
	localparam int unsigned MODE_W     = 2;

	// Event kinds on the input channel
	typedef enum logic [MODE_W-1:0] {
		MODE_RX_START = 2'd0,
		MODE_RX_END   = 2'd1,
		MODE_TX_START = 2'd2,
		MODE_TX_END   = 2'd3
	} evt_mode_t;

	// Radio state as reported on the result channel
	typedef enum logic [1:0] {
		PHY_IDLE = 2'd0,
		PHY_RX   = 2'd1,
		PHY_TX   = 2'd2
	} phy_state_t;

	// Controller sequencing
	typedef enum logic [1:0] {
		CS_IDLE,
		CS_SCAN,
		CS_DONE
	} ctrl_state_t;

	// One result item
	typedef struct packed {
		phy_state_t              phy_state;
		logic                    deliver;
		logic [ID_FIELD_W-1:0]   delivered_id;
		logic                    carrier_sense_begin;
		logic                    carrier_sense_end;
		logic                    transmit_finished;
		logic                    table_overflow;
		logic                    misuse_error;
	} res_t;

endpackage

### rtl/hpct_if.sv
// ----------------------------------------------------------------------------
// hpct_if
// Valid/ready channel interfaces: configuration, event input, result output.
// ----------------------------------------------------------------------------

// Configuration write channel
interface hpct_cfg_if;
	logic valid;
	logic ready;
	logic collisions_enabled;

	modport source (output valid, output collisions_enabled, input ready);
	modport sink (input valid, input collisions_enabled, output ready);
endinterface

// Event input channel
interface hpct_evt_if;
	logic                                 valid;
	logic                                 ready;
	logic [hpct_pkg::MODE_W-1:0]          mode;
	logic [hpct_pkg::ID_FIELD_W-1:0]      reception_id;

	modport source (output valid, output mode, output reception_id, input ready);
	modport sink (input valid, input mode, input reception_id, output ready);
endinterface

// Result output channel
interface hpct_res_if;
	logic                                 valid;
	logic                                 ready;
	logic [1:0]                           phy_state;
	logic                                 deliver;
	logic [hpct_pkg::ID_FIELD_W-1:0]      delivered_id;
	logic                                 carrier_sense_begin;
	logic                                 carrier_sense_end;
	logic                                 transmit_finished;
	logic                                 table_overflow;
	logic                                 misuse_error;

	modport source (output valid, output phy_state, output deliver, output delivered_id,
		output carrier_sense_begin, output carrier_sense_end, output transmit_finished,
		output table_overflow, output misuse_error, input ready);
	modport sink (input valid, input phy_state, input deliver, input delivered_id,
		input carrier_sense_begin, input carrier_sense_end, input transmit_finished,
		input table_overflow, input misuse_error, output ready);
endinterface

### rtl/halfduplex_phy_collision_tracker.sv
// ----------------------------------------------------------------------------
// halfduplex_phy_collision_tracker
// Half-duplex radio PHY state and reception table with collision marking.
// ----------------------------------------------------------------------------
// Usage:
//   evt : one item per PHY event (start/finish receive by id, start/finish
//         transmit). Items are taken one at a time; ready is high while the
//         sequencer is free.
//   res : exactly one item per event: new PHY state, delivery of a finished
//         reception, carrier-sense begin/end, transmit done, table overflow
//         and misuse flags.
//   cfg : single-bit collisions_enabled register, write while no item is in
//         flight. Always ready.
// Flow: start/finish transmit and start receive build their result in the
//   sequencer's result register on accept. A finish receive scans the id
//   store one slot per cycle through its registered read port, stopping at
//   the first live slot with the id or after the last slot. The next item is
//   accepted once the result has moved into the output register, so items do
//   not overlap in the sequencer.
// Reset: PHY idle, table empty, collisions_enabled = 1; the id store needs no
//   clearing since only valid slots are compared.
// Stall: a held result stays in the output register; one more finished result
//   waits in the sequencer, which then stops accepting items.
// ----------------------------------------------------------------------------
module halfduplex_phy_collision_tracker #(
	parameter int unsigned MAX_RECEPTIONS = 8,
	parameter int unsigned ID_WIDTH       = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	hpct_cfg_if.sink    cfg,
	hpct_evt_if.sink    evt,
	hpct_res_if.source  res
);

	localparam int unsigned IDX_W = $clog2(MAX_RECEPTIONS);

	logic                      coll_en_q;
	logic                      done_valid;
	hpct_pkg::res_t            done_res;
	logic                      done_ack;
	logic                      res_vld_q;
	hpct_pkg::res_t            res_q;
	logic                      mem_wr_en;
	logic [IDX_W-1:0]          mem_wr_addr;
	logic [ID_WIDTH-1:0]       mem_wr_data;
	logic                      mem_rd_en;
	logic [IDX_W-1:0]          mem_rd_addr;
	logic [ID_WIDTH-1:0]       mem_rd_data;
	logic [MAX_RECEPTIONS-1:0] slot_valid;
	logic [MAX_RECEPTIONS-1:0] slot_corrupt;

	// Configuration register
	assign cfg.ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coll_en_q <= 1'b1;
		end else if (cfg.valid) begin
			coll_en_q <= cfg.collisions_enabled;
		end
	end

	hpct_ctrl #(
		.MAX_RECEPTIONS (MAX_RECEPTIONS),
		.ID_WIDTH       (ID_WIDTH)
	) u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.coll_en      (coll_en_q),
		.evt_valid    (evt.valid),
		.evt_mode     (evt.mode),
		.evt_id       (evt.reception_id),
		.evt_ready    (evt.ready),
		.done_valid   (done_valid),
		.done_res     (done_res),
		.done_ack     (done_ack),
		.mem_wr_en    (mem_wr_en),
		.mem_wr_addr  (mem_wr_addr),
		.mem_wr_data  (mem_wr_data),
		.mem_rd_en    (mem_rd_en),
		.mem_rd_addr  (mem_rd_addr),
		.mem_rd_data  (mem_rd_data),
		.slot_valid   (slot_valid),
		.slot_corrupt (slot_corrupt)
	);

	hpct_id_mem #(
		.DEPTH (MAX_RECEPTIONS),
		.WIDTH (ID_WIDTH)
	) u_id_mem (
		.clk     (clk),
		.wr_en   (mem_wr_en),
		.wr_addr (mem_wr_addr),
		.wr_data (mem_wr_data),
		.rd_en   (mem_rd_en),
		.rd_addr (mem_rd_addr),
		.rd_data (mem_rd_data)
	);

	// Output register
	assign done_ack = done_valid && (!res_vld_q || res.ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_vld_q <= 1'b0;
		end else if (done_ack) begin
			res_vld_q <= 1'b1;
		end else if (res.ready) begin
			res_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (done_ack) begin
			res_q <= done_res;
		end
	end

	assign res.valid               = res_vld_q;
	assign res.phy_state           = res_q.phy_state;
	assign res.deliver             = res_q.deliver;
	assign res.delivered_id        = res_q.delivered_id;
	assign res.carrier_sense_begin = res_q.carrier_sense_begin;
	assign res.carrier_sense_end   = res_q.carrier_sense_end;
	assign res.transmit_finished   = res_q.transmit_finished;
	assign res.table_overflow      = res_q.table_overflow;
	assign res.misuse_error        = res_q.misuse_error;

	// Checks
	a_corrupt_in_valid: assert property (@(posedge clk) disable iff (!arst_n)
		(slot_corrupt & ~slot_valid) == '0)
		else $error("corrupted mark on a free slot");

	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		(evt.valid && evt.ready) |=> !evt.ready)
		else $error("second item accepted while one is in work");

	a_done_held: assert property (@(posedge clk) disable iff (!arst_n)
		(done_valid && !done_ack) |=> (done_valid && $stable(done_res)))
		else $error("finished result lost while output stalled");

	a_cs_end_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(res_vld_q && res_q.carrier_sense_end) |-> (res_q.phy_state == hpct_pkg::PHY_IDLE))
		else $error("carrier-sense end without idle state");

endmodule

### rtl/hpct_id_mem.sv
// ----------------------------------------------------------------------------
// hpct_id_mem
// Reception id store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module hpct_id_mem #(
	parameter int unsigned DEPTH = 8,
	parameter int unsigned WIDTH = 16
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	// Read port, registered read data
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

### rtl/hpct_ctrl.sv
// ----------------------------------------------------------------------------
// hpct_ctrl
// Event sequencer: slot bookkeeping, id scan through the store, result build.
// ----------------------------------------------------------------------------
module hpct_ctrl #(
	parameter int unsigned MAX_RECEPTIONS = 8,
	parameter int unsigned ID_WIDTH       = 16
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   coll_en,
	// event side
	input  logic                                   evt_valid,
	input  logic [hpct_pkg::MODE_W-1:0]            evt_mode,
	input  logic [hpct_pkg::ID_FIELD_W-1:0]        evt_id,
	output logic                                   evt_ready,
	// finished result
	output logic                                   done_valid,
	output hpct_pkg::res_t                         done_res,
	input  logic                                   done_ack,
	// id store
	output logic                                   mem_wr_en,
	output logic [$clog2(MAX_RECEPTIONS)-1:0]      mem_wr_addr,
	output logic [ID_WIDTH-1:0]                    mem_wr_data,
	output logic                                   mem_rd_en,
	output logic [$clog2(MAX_RECEPTIONS)-1:0]      mem_rd_addr,
	input  logic [ID_WIDTH-1:0]                    mem_rd_data,
	// slot status
	output logic [MAX_RECEPTIONS-1:0]              slot_valid,
	output logic [MAX_RECEPTIONS-1:0]              slot_corrupt
);

	localparam int unsigned IDX_W = $clog2(MAX_RECEPTIONS);
	localparam int unsigned CNT_W = IDX_W + 1;
	localparam int unsigned IW    = hpct_pkg::ID_FIELD_W;
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(MAX_RECEPTIONS - 1);
	localparam logic [CNT_W-1:0] N_SLOTS  = CNT_W'(MAX_RECEPTIONS);

	hpct_pkg::ctrl_state_t state_q, state_d;
	hpct_pkg::phy_state_t  phy_q, phy_d;
	logic [MAX_RECEPTIONS-1:0] valid_q, valid_d;
	logic [MAX_RECEPTIONS-1:0] corrupt_q, corrupt_d;
	logic [ID_WIDTH-1:0]       id_q;
	logic [CNT_W-1:0]          scan_q;
	logic                      chk_vld_s1;
	logic [IDX_W-1:0]          chk_idx_s1;
	hpct_pkg::res_t            res_q, res_d;
	logic                      res_load;

	logic                      evt_fire;
	logic [ID_WIDTH-1:0]       id_in;
	logic [IW-1:0]             id_out;
	logic                      free_any;
	logic [IDX_W-1:0]          free_idx;
	logic [MAX_RECEPTIONS-1:0] free_oh;
	logic [MAX_RECEPTIONS-1:0] hit_oh;
	logic                      hit;
	logic                      scan_end;
	logic                      scan_issue;

	assign evt_fire = evt_valid && evt_ready;

	// Id width adaption between the 16-bit field and the stored id
	if (ID_WIDTH <= IW) begin : g_id_narrow
		assign id_in  = evt_id[ID_WIDTH-1:0];
		assign id_out = IW'(id_q);
	end else begin : g_id_wide
		assign id_in  = ID_WIDTH'(evt_id);
		assign id_out = id_q[IW-1:0];
	end

	// Lowest free slot
	always_comb begin
		free_any = 1'b0;
		free_idx = '0;
		for (int i = MAX_RECEPTIONS - 1; i >= 0; i--) begin
			if (!valid_q[i]) begin
				free_any = 1'b1;
				free_idx = IDX_W'(i);
			end
		end
	end
	assign free_oh = {{(MAX_RECEPTIONS-1){1'b0}}, 1'b1} << free_idx;

	// Compare of the id read back against the searched id
	assign hit_oh     = {{(MAX_RECEPTIONS-1){1'b0}}, 1'b1} << chk_idx_s1;
	assign hit        = chk_vld_s1 && valid_q[chk_idx_s1] && (mem_rd_data == id_q);
	assign scan_end   = (state_q == hpct_pkg::CS_SCAN) && chk_vld_s1
		&& (hit || (chk_idx_s1 == LAST_IDX));
	assign scan_issue = (state_q == hpct_pkg::CS_SCAN) && !scan_end && (scan_q < N_SLOTS);

	// Store access
	assign mem_rd_en   = scan_issue;
	assign mem_rd_addr = scan_q[IDX_W-1:0];
	assign mem_wr_addr = free_idx;
	assign mem_wr_data = id_in;

	// Slot update and result build
	always_comb begin
		valid_d   = valid_q;
		corrupt_d = corrupt_q;
		phy_d     = phy_q;
		res_d     = res_q;
		res_load  = 1'b0;
		mem_wr_en = 1'b0;
		if (evt_fire) begin
			res_d = '0;
			case (hpct_pkg::evt_mode_t'(evt_mode))
				hpct_pkg::MODE_RX_START: begin
					res_load = 1'b1;
					if (!free_any) begin
						res_d.table_overflow = 1'b1;
					end else begin
						mem_wr_en = 1'b1;
						valid_d   = valid_q | free_oh;
						corrupt_d = corrupt_q & ~free_oh;
						if (coll_en && ((|valid_q) || (phy_q == hpct_pkg::PHY_TX))) begin
							corrupt_d = valid_d;
						end
						if (phy_q == hpct_pkg::PHY_IDLE) begin
							phy_d = hpct_pkg::PHY_RX;
							res_d.carrier_sense_begin = 1'b1;
						end
					end
				end
				hpct_pkg::MODE_TX_START: begin
					res_load = 1'b1;
					if (phy_q == hpct_pkg::PHY_TX) begin
						res_d.misuse_error = 1'b1;
					end else begin
						phy_d = hpct_pkg::PHY_TX;
						if (coll_en) begin
							corrupt_d = valid_q;
						end
					end
				end
				hpct_pkg::MODE_TX_END: begin
					res_load = 1'b1;
					phy_d = (|valid_q) ? hpct_pkg::PHY_RX : hpct_pkg::PHY_IDLE;
					res_d.transmit_finished = 1'b1;
				end
				default: begin
					// finish receive: resolved after the scan
				end
			endcase
			res_d.phy_state = phy_d;
		end else if (scan_end) begin
			res_d    = '0;
			res_load = 1'b1;
			if (hit) begin
				valid_d   = valid_q & ~hit_oh;
				corrupt_d = corrupt_q & ~hit_oh;
				if (!coll_en || !corrupt_q[chk_idx_s1]) begin
					res_d.deliver      = 1'b1;
					res_d.delivered_id = id_out;
				end
			end
			if ((valid_d == '0) && (phy_q == hpct_pkg::PHY_RX)) begin
				phy_d = hpct_pkg::PHY_IDLE;
				res_d.carrier_sense_end = 1'b1;
			end
			res_d.phy_state = phy_d;
		end
	end

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			hpct_pkg::CS_IDLE: begin
				if (evt_fire) begin
					state_d = (hpct_pkg::evt_mode_t'(evt_mode) == hpct_pkg::MODE_RX_END)
						? hpct_pkg::CS_SCAN : hpct_pkg::CS_DONE;
				end
			end
			hpct_pkg::CS_SCAN: begin
				if (scan_end) begin
					state_d = hpct_pkg::CS_DONE;
				end
			end
			hpct_pkg::CS_DONE: begin
				if (done_ack) begin
					state_d = hpct_pkg::CS_IDLE;
				end
			end
			default: state_d = hpct_pkg::CS_IDLE;
		endcase
	end

	// Handshake outputs
	always_comb begin
		evt_ready  = (state_q == hpct_pkg::CS_IDLE);
		done_valid = (state_q == hpct_pkg::CS_DONE);
	end

	// Control and slot state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= hpct_pkg::CS_IDLE;
			phy_q      <= hpct_pkg::PHY_IDLE;
			valid_q    <= '0;
			corrupt_q  <= '0;
			scan_q     <= '0;
			chk_vld_s1 <= 1'b0;
		end else begin
			state_q   <= state_d;
			phy_q     <= phy_d;
			valid_q   <= valid_d;
			corrupt_q <= corrupt_d;
			if (evt_fire) begin
				scan_q     <= '0;
				chk_vld_s1 <= 1'b0;
			end else if (scan_issue) begin
				scan_q     <= scan_q + CNT_W'(1);
				chk_vld_s1 <= 1'b1;
			end else begin
				chk_vld_s1 <= 1'b0;
			end
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		if (evt_fire) begin
			id_q <= id_in;
		end
		if (scan_issue) begin
			chk_idx_s1 <= scan_q[IDX_W-1:0];
		end
		if (res_load) begin
			res_q <= res_d;
		end
	end

	assign done_res     = res_q;
	assign slot_valid   = valid_q;
	assign slot_corrupt = corrupt_q;

endmodule

### test/tb_halfduplex_phy_collision_tracker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_halfduplex_phy_collision_tracker
// Self-checking bench for the half-duplex PHY collision tracker. A directed
// set of events runs first: deliveries, overlaps, transmit misuse, a full
// table and the collisions register switched off while marks are held. Long
// stretches of random receive/transmit traffic follow, under several
// register settings. Every event is predicted by a behavioural copy of the
// PHY and checked field by field against the result channel. Both the event
// sender and the result sink stall at random.
// ----------------------------------------------------------------------------
module tb_halfduplex_phy_collision_tracker;

	localparam int NUM_SLOTS   = 8;
	localparam int DRAIN_WAIT  = 12;
	localparam int STALL_LIMIT = 4000;

	logic clk;
	logic arst_n;

	hpct_cfg_if cfg_ch ();
	hpct_evt_if evt_ch ();
	hpct_res_if res_ch ();

	halfduplex_phy_collision_tracker dut (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg_ch),
		.evt    (evt_ch),
		.res    (res_ch)
	);

	// Behavioural copy of the PHY state and register
	hpct_pkg::phy_state_t radio;
	bit                   slot_live [NUM_SLOTS];
	logic [15:0]          slot_tag [NUM_SLOTS];
	bit                   slot_hit [NUM_SLOTS];
	bit                   collide_on;

	hpct_pkg::res_t expected_results [$];
	int             errors;
	int             idle_cycles;
	int             sink_hold;
	int             sink_phase;
	bit             sink_quiet;

	// Clock
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic int occupancy();
		int n;
		n = 0;
		for (int i = 0; i < NUM_SLOTS; i++)
			if (slot_live[i])
				n++;
		return n;
	endfunction

	function automatic void mark_all_corrupted();
		for (int i = 0; i < NUM_SLOTS; i++)
			if (slot_live[i])
				slot_hit[i] = 1'b1;
	endfunction

	// Apply one event to the copy of the PHY and return its result
	function automatic hpct_pkg::res_t phy_predict(hpct_pkg::evt_mode_t m, logic [15:0] id);
		hpct_pkg::res_t r;
		int             free_idx;
		bit             found;
		r = '0;
		free_idx = -1;
		found = 1'b0;
		case (m)
			hpct_pkg::MODE_RX_START: begin
				for (int i = 0; i < NUM_SLOTS; i++)
					if (!slot_live[i] && free_idx < 0)
						free_idx = i;
				if (free_idx < 0) begin
					r.table_overflow = 1'b1;
				end else begin
					slot_live[free_idx] = 1'b1;
					slot_tag[free_idx]  = id;
					slot_hit[free_idx]  = 1'b0;
					if (collide_on && (occupancy() > 1 || radio == hpct_pkg::PHY_TX))
						mark_all_corrupted();
					if (radio == hpct_pkg::PHY_IDLE) begin
						radio = hpct_pkg::PHY_RX;
						r.carrier_sense_begin = 1'b1;
					end
				end
			end
			hpct_pkg::MODE_RX_END: begin
				// lowest-numbered live slot with the id wins
				for (int i = 0; i < NUM_SLOTS; i++) begin
					if (!found && slot_live[i] && slot_tag[i] == id) begin
						found = 1'b1;
						if (!collide_on || !slot_hit[i]) begin
							r.deliver      = 1'b1;
							r.delivered_id = id;
						end
						slot_live[i] = 1'b0;
						slot_hit[i]  = 1'b0;
					end
				end
				if (occupancy() == 0 && radio == hpct_pkg::PHY_RX) begin
					radio = hpct_pkg::PHY_IDLE;
					r.carrier_sense_end = 1'b1;
				end
			end
			hpct_pkg::MODE_TX_START: begin
				if (radio == hpct_pkg::PHY_TX) begin
					r.misuse_error = 1'b1;
				end else begin
					radio = hpct_pkg::PHY_TX;
					if (collide_on)
						mark_all_corrupted();
				end
			end
			default: begin
				radio = (occupancy() != 0) ? hpct_pkg::PHY_RX : hpct_pkg::PHY_IDLE;
				r.transmit_finished = 1'b1;
			end
		endcase
		r.phy_state = radio;
		return r;
	endfunction

	// Gap length: mostly none or short, now and then long
	function automatic int gap_len(bit quiet);
		int r;
		if (quiet)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// Id of a random live slot, or the fallback when the table is empty
	function automatic logic [15:0] live_id_or(logic [15:0] fallback);
		int n;
		int k;
		n = occupancy();
		if (n == 0)
			return fallback;
		k = $urandom_range(0, n - 1);
		for (int i = 0; i < NUM_SLOTS; i++) begin
			if (slot_live[i]) begin
				if (k == 0)
					return slot_tag[i];
				k--;
			end
		end
		return fallback;
	endfunction

	// Send one event item; starts and ends at a falling edge
	task automatic send_event(hpct_pkg::evt_mode_t m, logic [15:0] id, int gap);
		hpct_pkg::res_t want;
		if (gap > 0) begin
			evt_ch.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		evt_ch.valid        <= 1'b1;
		evt_ch.mode         <= m;
		evt_ch.reception_id <= id;
		do
			@(posedge clk);
		while (!evt_ch.ready);
		want = phy_predict(m, id);
		expected_results.insert(expected_results.size(), want);
		@(negedge clk);
	endtask

	// Hold off the sender until every result is back
	task automatic wait_drained();
		evt_ch.valid <= 1'b0;
		while (expected_results.size() != 0)
			@(negedge clk);
		@(negedge clk);
	endtask

	// Register write, only with the block idle
	task automatic write_collisions(bit en);
		wait_drained();
		repeat (DRAIN_WAIT) @(negedge clk);
		cfg_ch.valid              <= 1'b1;
		cfg_ch.collisions_enabled <= en;
		do
			@(posedge clk);
		while (!cfg_ch.ready);
		collide_on = en;
		@(negedge clk);
		cfg_ch.valid <= 1'b0;
	endtask

	// Single receptions, unknown id while idle, id extremes
	task automatic test_basic_receive();
		write_collisions(1'b1);
		send_event(hpct_pkg::MODE_RX_END, 16'h1234, 0);
		send_event(hpct_pkg::MODE_RX_START, 16'h0000, 0);
		send_event(hpct_pkg::MODE_RX_END, 16'h0000, 1);
		send_event(hpct_pkg::MODE_RX_START, 16'hFFFF, 0);
		send_event(hpct_pkg::MODE_RX_END, 16'hFFFF, 0);
	endtask

	// Two overlapping receptions corrupt each other
	task automatic test_overlap();
		send_event(hpct_pkg::MODE_RX_START, 16'hA5A5, 0);
		send_event(hpct_pkg::MODE_RX_START, 16'h5A5A, 2);
		send_event(hpct_pkg::MODE_RX_END, 16'h5A5A, 0);
		send_event(hpct_pkg::MODE_RX_END, 16'hA5A5, 0);
	endtask

	// Transmit from idle, misuse, reception during transmit, finish to receive
	task automatic test_transmit();
		send_event(hpct_pkg::MODE_TX_END, 16'h0000, 0);
		send_event(hpct_pkg::MODE_TX_START, 16'h0000, 0);
		send_event(hpct_pkg::MODE_TX_START, 16'hFFFF, 0);
		send_event(hpct_pkg::MODE_RX_START, 16'h0001, 0);
		send_event(hpct_pkg::MODE_TX_END, 16'h0000, 0);
	endtask

	// Fill the table (with a duplicate id) and overflow it
	task automatic test_table_full();
		send_event(hpct_pkg::MODE_RX_START, 16'h00FF, 0);
		send_event(hpct_pkg::MODE_RX_START, 16'h8000, 0);
		send_event(hpct_pkg::MODE_RX_START, 16'h00FF, 0);
		send_event(hpct_pkg::MODE_RX_START, 16'h0F0F, 0);
		send_event(hpct_pkg::MODE_RX_START, 16'hF0F0, 0);
		send_event(hpct_pkg::MODE_RX_START, 16'h7FFF, 0);
		send_event(hpct_pkg::MODE_RX_START, 16'h3C3C, 0);
		send_event(hpct_pkg::MODE_RX_START, 16'hBEEF, 3);
	endtask

	// Marks set earlier do not block delivery once collisions are off
	task automatic test_collisions_off();
		write_collisions(1'b0);
		send_event(hpct_pkg::MODE_RX_END, 16'h00FF, 0);
		send_event(hpct_pkg::MODE_RX_END, 16'h0001, 0);
	endtask

	// Random traffic: mostly ids that are live or from a small pool
	task automatic test_random_traffic(int n_items);
		int                  start_pct;
		bit                  quiet;
		int                  r;
		hpct_pkg::evt_mode_t m;
		logic [15:0]         id;
		start_pct = 40;
		quiet = 1'b0;
		for (int i = 0; i < n_items; i++) begin
			if (i % 40 == 0) begin
				start_pct = $urandom_range(20, 60);
				quiet = ($urandom_range(0, 3) == 0);
			end
			if ($urandom_range(0, 199) == 0)
				wait_drained();
			r = $urandom_range(0, 99);
			if (r < start_pct)
				m = hpct_pkg::MODE_RX_START;
			else if (r < 82)
				m = hpct_pkg::MODE_RX_END;
			else if (r < 91)
				m = hpct_pkg::MODE_TX_START;
			else
				m = hpct_pkg::MODE_TX_END;
			r = $urandom_range(0, 99);
			if (m == hpct_pkg::MODE_RX_START)
				id = (r < 60) ? 16'($urandom_range(0, 15)) :
				     (r < 70) ? live_id_or(16'($urandom_range(0, 15))) :
				     16'($urandom_range(0, 65535));
			else if (m == hpct_pkg::MODE_RX_END)
				id = (r < 75) ? live_id_or(16'($urandom_range(0, 15))) :
				     (r < 88) ? 16'($urandom_range(0, 15)) :
				     16'($urandom_range(0, 65535));
			else
				id = 16'($urandom_range(0, 65535));
			send_event(m, id, gap_len(quiet));
		end
	endtask

	task automatic check_field(string name, logic [15:0] want, logic [15:0] got);
		if (got !== want) begin
			errors++;
			$display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h",
				$time, name, want, got);
		end
	endtask

	// Result checker
	always @(posedge clk) begin : result_check
		hpct_pkg::res_t want;
		if (res_ch.valid && res_ch.ready) begin
			if (expected_results.size() == 0) begin
				errors++;
				$display("%0t: result item mismatch, expected none, actual state %0d",
					$time, res_ch.phy_state);
			end else begin
				want = expected_results.pop_front();
				check_field("phy_state", 16'(want.phy_state), 16'(res_ch.phy_state));
				check_field("deliver", 16'(want.deliver), 16'(res_ch.deliver));
				check_field("delivered_id", want.delivered_id, res_ch.delivered_id);
				check_field("carrier_sense_begin", 16'(want.carrier_sense_begin),
					16'(res_ch.carrier_sense_begin));
				check_field("carrier_sense_end", 16'(want.carrier_sense_end),
					16'(res_ch.carrier_sense_end));
				check_field("transmit_finished", 16'(want.transmit_finished),
					16'(res_ch.transmit_finished));
				check_field("table_overflow", 16'(want.table_overflow),
					16'(res_ch.table_overflow));
				check_field("misuse_error", 16'(want.misuse_error),
					16'(res_ch.misuse_error));
			end
		end
	end

	// Result sink with random stalls and quiet stretches
	always @(negedge clk) begin
		if (sink_hold > 0) begin
			res_ch.ready <= 1'b0;
			sink_hold--;
		end else begin
			res_ch.ready <= 1'b1;
			sink_hold = gap_len(sink_quiet);
		end
		sink_phase++;
		if (sink_phase % 300 == 0)
			sink_quiet = ($urandom_range(0, 2) == 0);
	end

	// Watchdog on cycles with no item moving on any channel
	always @(posedge clk) begin
		if ((evt_ch.valid && evt_ch.ready) || (res_ch.valid && res_ch.ready) ||
		    (cfg_ch.valid && cfg_ch.ready))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= STALL_LIMIT) begin
			$display("%0t: no progress for %0d cycles", $time, STALL_LIMIT);
			$display("tb_halfduplex_phy_collision_tracker failed");
			$finish;
		end
	end

	// Main sequence
	initial begin
		arst_n                    = 1'b0;
		cfg_ch.valid              = 1'b0;
		cfg_ch.collisions_enabled = 1'b1;
		evt_ch.valid              = 1'b0;
		evt_ch.mode               = hpct_pkg::MODE_RX_START;
		evt_ch.reception_id       = '0;
		res_ch.ready              = 1'b0;
		errors      = 0;
		idle_cycles = 0;
		sink_hold   = 0;
		sink_phase  = 0;
		sink_quiet  = 1'b0;
		radio       = hpct_pkg::PHY_IDLE;
		collide_on  = 1'b1;
		for (int i = 0; i < NUM_SLOTS; i++) begin
			slot_live[i] = 1'b0;
			slot_tag[i]  = '0;
			slot_hit[i]  = 1'b0;
		end
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		test_basic_receive();
		test_overlap();
		test_transmit();
		test_table_full();
		test_collisions_off();
		test_random_traffic(600);
		write_collisions(1'b1);
		test_random_traffic(700);
		write_collisions(1'b0);
		test_random_traffic(300);
		write_collisions(1'b1);
		test_random_traffic(300);

		wait_drained();
		repeat (15) @(posedge clk);
		if (expected_results.size() != 0)
			errors++;
		if (errors == 0)
			$display("tb_halfduplex_phy_collision_tracker passed");
		else
			$display("tb_halfduplex_phy_collision_tracker failed");
		$finish;
	end

endmodule
